// File: sv/retransmit_slot_table_core_defines.svh
// Assertion macros for the retransmit slot table core
`ifndef RETRANSMIT_SLOT_TABLE_CORE_DEFINES_SVH
`define RETRANSMIT_SLOT_TABLE_CORE_DEFINES_SVH

// check prop at every edge out of reset
`define RST_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("retransmit slot table assertion failed");

// check that cond implies res in the following cycle
`define RST_ASSERT_NEXT(lbl, clk, rstn, cond, res) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (res)) \
    else $error("retransmit slot table assertion failed");

`endif

// File: sv/rst_pkg.sv
// Package with types and constants of the retransmit slot table
package rst_pkg;

  localparam int SlotCount       = 8;
  localparam int SlotW           = 3;
  localparam int PendW           = 4;
  localparam int MaxStoredLenDef = 256;
  localparam int CfgIdxW         = 2;
  localparam int CfgDataW        = 16;

  localparam logic [CfgIdxW-1:0] CFG_LINK_READY  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT_MS  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_RETRY_LIMIT = 2'd2;

  typedef enum logic [1:0] {
    CMD_SEND = 2'd0,
    CMD_ACK  = 2'd1,
    CMD_SCAN = 2'd2,
    CMD_BAD  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_SENT_TRACKED   = 3'd0,
    KIND_SENT_UNTRACKED = 3'd1,
    KIND_REJECTED       = 3'd2,
    KIND_ACK_CLEARED    = 3'd3,
    KIND_ACK_UNKNOWN    = 3'd4,
    KIND_RETRANSMIT     = 3'd5,
    KIND_DROPPED        = 3'd6,
    KIND_SCAN_DONE      = 3'd7
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SEARCH,
    ST_COMMIT,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_SEARCH,
    OP_COMMIT,
    OP_SCAN,
    OP_EMIT
  } op_e;

  typedef struct packed {
    op_e   op;
    kind_e kind;
  } ctrl_t;

  typedef struct packed {
    cmd_e cmd;
    logic reject;
    logic too_long;
    logic scan_idle;
    logic idx_last;
  } stat_t;

endpackage

// File: sv/rst_ctrl.sv
// Controller state machine of the retransmit slot table
module rst_ctrl import rst_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start,
  output logic  busy,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        unique case (stat_i.cmd)
          CMD_SEND: state_d = (stat_i.reject || stat_i.too_long) ? ST_IDLE : ST_SEARCH;
          CMD_ACK:  state_d = ST_SEARCH;
          CMD_SCAN: state_d = stat_i.scan_idle ? ST_IDLE : ST_SCAN;
          default:  state_d = ST_IDLE;
        endcase
      end
      ST_SEARCH: begin
        if (stat_i.idx_last) state_d = ST_COMMIT;
      end
      ST_COMMIT: state_d = ST_IDLE;
      ST_SCAN: begin
        if (stat_i.idx_last) state_d = ST_DONE;
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o.op   = OP_NONE;
    ctrl_o.kind = KIND_REJECTED;
    unique case (state_q)
      ST_IDLE: begin
        if (start) ctrl_o.op = OP_LOAD;
      end
      ST_DISPATCH: begin
        unique case (stat_i.cmd)
          CMD_SEND: begin
            if (stat_i.reject) begin
              ctrl_o.op = OP_EMIT;
            end else if (stat_i.too_long) begin
              ctrl_o.op   = OP_EMIT;
              ctrl_o.kind = KIND_SENT_UNTRACKED;
            end
          end
          CMD_ACK: ctrl_o.op = OP_NONE;
          CMD_SCAN: begin
            if (stat_i.scan_idle) begin
              ctrl_o.op   = OP_EMIT;
              ctrl_o.kind = KIND_SCAN_DONE;
            end
          end
          default: ctrl_o.op = OP_EMIT;
        endcase
      end
      ST_SEARCH: ctrl_o.op = OP_SEARCH;
      ST_COMMIT: ctrl_o.op = OP_COMMIT;
      ST_SCAN:   ctrl_o.op = OP_SCAN;
      ST_DONE: begin
        ctrl_o.op   = OP_EMIT;
        ctrl_o.kind = KIND_SCAN_DONE;
      end
      default: ctrl_o.op = OP_NONE;
    endcase
  end

  assign busy = (state_q != ST_IDLE);

endmodule

// File: sv/rst_datapath.sv
// Datapath of the retransmit slot table: slot store, walk index, result beat
module rst_datapath import rst_pkg::*; #(
  parameter int MaxStoredLen = MaxStoredLenDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctrl_t               ctrl_i,
  output stat_t               stat_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic [1:0]          cmd_i,
  input  logic [15:0]         msg_id_i,
  input  logic [15:0]         msg_len_i,
  input  logic                has_dest_i,
  input  logic [47:0]         dest_addr_i,
  input  logic [31:0]         now_ms_i,
  output logic                valid_o,
  output logic [2:0]          kind_o,
  output logic [SlotW-1:0]    slot_o,
  output logic [15:0]         out_msg_id_o,
  output logic [15:0]         out_len_o,
  output logic                out_has_dest_o,
  output logic [47:0]         out_dest_o,
  output logic [7:0]          retry_number_o,
  output logic [PendW-1:0]    pending_o,
  output logic                last_o
);

  localparam int LenW = $clog2(MaxStoredLen + 1);

  logic        link_q;
  logic [15:0] timeout_q;
  logic [7:0]  limit_q;

  cmd_e        cmd_q;
  logic [15:0] id_q;
  logic [15:0] len_q;
  logic        hd_q;
  logic [47:0] dest_q;
  logic [31:0] now_q;

  logic [SlotW-1:0] idx_q;
  logic             mfound_q, ffound_q;
  logic [SlotW-1:0] midx_q, fidx_q;

  logic [SlotCount-1:0] act_q;
  logic [15:0]          sid_q   [SlotCount];
  logic [LenW-1:0]      slen_q  [SlotCount];
  logic [7:0]           sret_q  [SlotCount];
  logic [31:0]          sdl_q   [SlotCount];
  logic [SlotCount-1:0] shd_q;
  logic [47:0]          sdest_q [SlotCount];
  logic [PendW-1:0]     pend_q, pend_d;

  logic             out_valid_q, out_valid_d;
  logic             out_last_q, out_last_d;
  logic [2:0]       out_kind_q, out_kind_d;
  logic [SlotW-1:0] out_slot_q, out_slot_d;
  logic [15:0]      out_id_q, out_id_d;
  logic [15:0]      out_len_q, out_len_d;
  logic             out_hd_q, out_hd_d;
  logic [47:0]      out_dest_q, out_dest_d;
  logic [7:0]       out_retry_q, out_retry_d;
  logic [PendW-1:0] out_pend_q;

  logic [PendW-1:0] pend_inc, pend_dec;
  logic [31:0]      deadline, age;
  logic             idx_last, expired, ok, over;
  logic [SlotW-1:0] tgt;

  assign pend_inc = pend_q + PendW'(1);
  assign pend_dec = (pend_q == '0) ? '0 : pend_q - PendW'(1);
  assign deadline = now_q + {16'd0, timeout_q};
  assign age      = now_q - sdl_q[idx_q];
  assign expired  = act_q[idx_q] && !age[31];
  assign over     = (sret_q[idx_q] >= limit_q);
  assign idx_last = (idx_q == SlotW'(SlotCount - 1));
  assign ok       = mfound_q || ffound_q;
  assign tgt      = mfound_q ? midx_q : fidx_q;

  assign stat_o.cmd       = cmd_q;
  assign stat_o.reject    = (len_q == '0) || !link_q;
  assign stat_o.too_long  = ({1'b0, len_q} > 17'(MaxStoredLen));
  assign stat_o.scan_idle = !link_q || (pend_q == '0);
  assign stat_o.idx_last  = idx_last;

  assign valid_o        = out_valid_q;
  assign last_o         = out_last_q;
  assign kind_o         = out_kind_q;
  assign slot_o         = out_slot_q;
  assign out_msg_id_o   = out_id_q;
  assign out_len_o      = out_len_q;
  assign out_has_dest_o = out_hd_q;
  assign out_dest_o     = out_dest_q;
  assign retry_number_o = out_retry_q;
  assign pending_o      = out_pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q    <= 1'b0;
      timeout_q <= 16'd100;
      limit_q   <= 8'd3;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LINK_READY:  link_q    <= cfg_wdata_i[0];
        CFG_TIMEOUT_MS:  timeout_q <= cfg_wdata_i;
        CFG_RETRY_LIMIT: limit_q   <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_d = 1'b0;
    out_last_d  = 1'b0;
    out_kind_d  = KIND_REJECTED;
    out_slot_d  = '0;
    out_id_d    = '0;
    out_len_d   = '0;
    out_hd_d    = 1'b0;
    out_dest_d  = '0;
    out_retry_d = '0;
    pend_d      = pend_q;
    unique case (ctrl_i.op)
      OP_COMMIT: begin
        out_valid_d = 1'b1;
        out_last_d  = 1'b1;
        out_id_d    = id_q;
        if (cmd_q == CMD_SEND) begin
          out_len_d  = len_q;
          out_hd_d   = hd_q;
          out_dest_d = dest_q;
          if (ok) begin
            out_slot_d = tgt;
            out_kind_d = KIND_SENT_TRACKED;
            if (!mfound_q) pend_d = pend_inc;
          end else begin
            out_kind_d = KIND_SENT_UNTRACKED;
          end
        end else if (mfound_q) begin
          out_slot_d = midx_q;
          out_kind_d = KIND_ACK_CLEARED;
          pend_d     = pend_dec;
        end else begin
          out_kind_d = KIND_ACK_UNKNOWN;
        end
      end
      OP_SCAN: begin
        if (expired) begin
          out_valid_d = 1'b1;
          out_slot_d  = idx_q;
          out_id_d    = sid_q[idx_q];
          out_retry_d = sret_q[idx_q];
          if (over) begin
            out_kind_d = KIND_DROPPED;
            pend_d     = pend_dec;
          end else begin
            out_kind_d = KIND_RETRANSMIT;
            out_len_d  = 16'(slen_q[idx_q]);
            out_hd_d   = shd_q[idx_q];
            out_dest_d = shd_q[idx_q] ? sdest_q[idx_q] : 48'd0;
          end
        end
      end
      OP_EMIT: begin
        out_valid_d = 1'b1;
        out_last_d  = 1'b1;
        out_kind_d  = ctrl_i.kind;
        out_id_d    = (ctrl_i.kind == KIND_SCAN_DONE) ? 16'd0 : id_q;
        if (ctrl_i.kind == KIND_SENT_UNTRACKED) begin
          out_len_d  = len_q;
          out_hd_d   = hd_q;
          out_dest_d = dest_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q    <= '0;
      shd_q    <= '0;
      pend_q   <= '0;
      idx_q    <= '0;
      mfound_q <= 1'b0;
      ffound_q <= 1'b0;
      midx_q   <= '0;
      fidx_q   <= '0;
      cmd_q    <= CMD_SEND;
      id_q     <= '0;
      len_q    <= '0;
      hd_q     <= 1'b0;
      dest_q   <= '0;
      now_q    <= '0;
      for (int i = 0; i < SlotCount; i++) begin
        sid_q[i]   <= '0;
        slen_q[i]  <= '0;
        sret_q[i]  <= '0;
        sdl_q[i]   <= '0;
        sdest_q[i] <= '0;
      end
    end else begin
      pend_q <= pend_d;
      unique case (ctrl_i.op)
        OP_LOAD: begin
          cmd_q    <= cmd_e'(cmd_i);
          id_q     <= msg_id_i;
          len_q    <= msg_len_i;
          hd_q     <= has_dest_i;
          dest_q   <= has_dest_i ? dest_addr_i : 48'd0;
          now_q    <= now_ms_i;
          idx_q    <= '0;
          mfound_q <= 1'b0;
          ffound_q <= 1'b0;
        end
        OP_SEARCH: begin
          if (act_q[idx_q] && sid_q[idx_q] == id_q && !mfound_q) begin
            mfound_q <= 1'b1;
            midx_q   <= idx_q;
          end
          if (!act_q[idx_q] && !ffound_q) begin
            ffound_q <= 1'b1;
            fidx_q   <= idx_q;
          end
          idx_q <= idx_last ? '0 : idx_q + SlotW'(1);
        end
        OP_COMMIT: begin
          if (cmd_q == CMD_SEND) begin
            if (ok) begin
              act_q[tgt]   <= 1'b1;
              sid_q[tgt]   <= id_q;
              slen_q[tgt]  <= len_q[LenW-1:0];
              sret_q[tgt]  <= '0;
              sdl_q[tgt]   <= deadline;
              shd_q[tgt]   <= hd_q;
              sdest_q[tgt] <= dest_q;
            end
          end else if (mfound_q) begin
            act_q[midx_q]  <= 1'b0;
            slen_q[midx_q] <= '0;
          end
        end
        OP_SCAN: begin
          if (expired) begin
            if (over) begin
              act_q[idx_q]  <= 1'b0;
              slen_q[idx_q] <= '0;
            end else begin
              sret_q[idx_q] <= sret_q[idx_q] + 8'd1;
              sdl_q[idx_q]  <= deadline;
            end
          end
          idx_q <= idx_last ? '0 : idx_q + SlotW'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_kind_q  <= '0;
      out_slot_q  <= '0;
      out_id_q    <= '0;
      out_len_q   <= '0;
      out_hd_q    <= 1'b0;
      out_dest_q  <= '0;
      out_retry_q <= '0;
      out_pend_q  <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      out_last_q  <= out_last_d;
      out_kind_q  <= out_kind_d;
      out_slot_q  <= out_slot_d;
      out_id_q    <= out_id_d;
      out_len_q   <= out_len_d;
      out_hd_q    <= out_hd_d;
      out_dest_q  <= out_dest_d;
      out_retry_q <= out_retry_d;
      out_pend_q  <= pend_d;
    end
  end

endmodule

// File: sv/retransmit_slot_table_core.sv
// Top level of the retransmit slot table: controller, datapath and checks
//
//  channel  | handshake            | fields
//  ---------+----------------------+-------------------------------------------
//  command  | start, busy          | cmd_i msg_id_i msg_len_i has_dest_i ...
//  result   | valid_o (strobe)     | kind_o slot_o out_msg_id_o ... last_o
//  config   | cfg_we_i, cfg_idx_i  | cfg_wdata_i
//
// Send and ack pass through load, dispatch, one walk step per slot, commit.
// Scan passes through load, dispatch, the walk and a scan-done beat; rejects and idle scans end at dispatch.
// The walk over the slot store goes one slot a cycle.
// Reset is asynchronous, active low, and empties the table.
// Results come as one-cycle strobed beats; the receiver cannot stall.
`include "retransmit_slot_table_core_defines.svh"

module retransmit_slot_table_core import rst_pkg::*; #(
  parameter int MaxStoredLen = MaxStoredLenDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          cmd_i,
  input  logic [15:0]         msg_id_i,
  input  logic [15:0]         msg_len_i,
  input  logic                has_dest_i,
  input  logic [47:0]         dest_addr_i,
  input  logic [31:0]         now_ms_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output logic                valid_o,
  output logic [2:0]          kind_o,
  output logic [SlotW-1:0]    slot_o,
  output logic [15:0]         out_msg_id_o,
  output logic [15:0]         out_len_o,
  output logic                out_has_dest_o,
  output logic [47:0]         out_dest_o,
  output logic [7:0]          retry_number_o,
  output logic [PendW-1:0]    pending_o,
  output logic                last_o
);

  ctrl_t ctrl;
  stat_t stat;

  rst_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  rst_datapath #(
    .MaxStoredLen (MaxStoredLen)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .stat_o         (stat),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .cmd_i          (cmd_i),
    .msg_id_i       (msg_id_i),
    .msg_len_i      (msg_len_i),
    .has_dest_i     (has_dest_i),
    .dest_addr_i    (dest_addr_i),
    .now_ms_i       (now_ms_i),
    .valid_o        (valid_o),
    .kind_o         (kind_o),
    .slot_o         (slot_o),
    .out_msg_id_o   (out_msg_id_o),
    .out_len_o      (out_len_o),
    .out_has_dest_o (out_has_dest_o),
    .out_dest_o     (out_dest_o),
    .retry_number_o (retry_number_o),
    .pending_o      (pending_o),
    .last_o         (last_o)
  );

  `RST_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start && !busy, busy)
  `RST_ASSERT(a_pending_max, clk_i, rst_ni, valid_o |-> (pending_o <= 4'd8))
  `RST_ASSERT(a_done_last, clk_i, rst_ni,
              (valid_o && kind_o == KIND_SCAN_DONE) |-> last_o)
  `RST_ASSERT(a_last_idle, clk_i, rst_ni, (valid_o && last_o) |-> !$past(busy) || !busy)

endmodule
